@@ hw/rtl/cmt_pkg.sv @@
// Shared types, register codes and the prescale table for the compare-match timer channel.
`timescale 1ns / 1ps
`default_nettype none

package cmt_pkg;

    // Default counter width
    localparam int CMT_COUNT_WIDTH = 16;

    // Bus-side field widths
    localparam int DATA_W  = 16;
    localparam int KIND_W  = 2;
    localparam int SEL_W   = 3;
    localparam int PSC_W   = 12;
    localparam int CODE_W  = 3;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

    // Register map
    localparam logic [SEL_W-1:0] REG_CMP_A  = 3'd0;
    localparam logic [SEL_W-1:0] REG_CMP_B  = 3'd1;
    localparam logic [SEL_W-1:0] REG_COUNT  = 3'd2;
    localparam logic [SEL_W-1:0] REG_CTRL   = 3'd3;
    localparam logic [SEL_W-1:0] REG_CLKCTL = 3'd4;
    localparam logic [SEL_W-1:0] REG_PAUSE  = 3'd5;

    // Control register bits
    localparam int CTRL_RUN    = 0;
    localparam int CTRL_PRESET = 1;
    localparam int CTRL_OE     = 2;
    localparam int CTRL_EXT    = 3;
    localparam int CTRL_INV    = 4;

    // Clock control register bits
    localparam int CLKCTL_EN = 3;

    // One input beat
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEL_W-1:0]  reg_select;
        logic [DATA_W-1:0] write_data;
    } item_t;

    // One result beat
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              timer_output;
        logic              match_a;
        logic              match_b;
    } result_t;

    // Core to prescaler control
    typedef struct packed {
        logic              tick_en;
        logic              clear;
        logic [CODE_W-1:0] code;
    } psc_ctl_t;

    // Prescale divisor: 1, 2, 4, 16, 64, 256, 1024, 4096
    function automatic logic [PSC_W:0] psc_divisor(input logic [CODE_W-1:0] code);
        logic [PSC_W:0] div;
        unique case (code)
            3'd0:    div = 13'd1;
            3'd1:    div = 13'd2;
            3'd2:    div = 13'd4;
            3'd3:    div = 13'd16;
            3'd4:    div = 13'd64;
            3'd5:    div = 13'd256;
            3'd6:    div = 13'd1024;
            default: div = 13'd4096;
        endcase
        return div;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/compare_match_timer_channel_unit.sv @@
// Top level of the compare-match timer channel: input register, core and result register.
//
//  Channel  Signals                          Beat
//  item     item_valid, item_stall, item     kind, reg_select, write_data
//  result   result_valid, result_stall,      read_data, timer_output,
//           result                           match_a, match_b
//
//  One item per cycle sustained while result_stall stays low; each result passes through the
//  input register, then the result register, before it is offered.
//  The core's single-pass update lies between the two registers.
//  Reset (rst_n low) clears all timer registers, the prescaler and both valid flags.
//  A stalled result holds the result register; the input register then holds and
//  item_stall rises only while it is full.
`timescale 1ns / 1ps
`default_nettype none

module compare_match_timer_channel_unit
    import cmt_pkg::*;
#(
    parameter int COUNT_WIDTH = CMT_COUNT_WIDTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_stall,
    input  wire item_t item,
    output logic       result_valid,
    input  wire logic  result_stall,
    output result_t    result
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    fire;
    result_t core_result;

    // Move the held item into the result register when that stage is free
    assign fire       = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !fire;

    cmt_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .result (core_result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_item_reg <= item;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= core_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Input side stalls only while a taken item is waiting behind a full result stage
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> in_valid_reg && out_valid_reg && result_stall)
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

@@ hw/rtl/cmt_prescale.sv @@
// Source-clock prescaler: counts qualified ticks and flags a count step at the divisor.
`timescale 1ns / 1ps
`default_nettype none

module cmt_prescale
    import cmt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire psc_ctl_t ctl,
    output logic          step
);

    logic [PSC_W-1:0] count_reg;
    logic [PSC_W-1:0] count_next;
    logic [PSC_W:0]   div;
    logic [PSC_W:0]   count_inc;

    // Terminal count detect
    always_comb
    begin
        div       = psc_divisor(ctl.code);
        count_inc = {1'b0, count_reg} + {{PSC_W{1'b0}}, 1'b1};
        step      = ctl.tick_en && (count_inc >= div);
    end

    // Next count
    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear || step)
        begin
            count_next = '0;
        end
        else if (ctl.tick_en)
        begin
            count_next = count_inc[PSC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // A clock control write restarts the prescaler
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> count_reg == '0)
        else $error("prescaler not cleared after clock control write");

endmodule

`default_nettype wire

@@ hw/rtl/cmt_core.sv @@
// Timer channel state, register decode, count step and output level logic.
`timescale 1ns / 1ps
`default_nettype none

module cmt_core
    import cmt_pkg::*;
#(
    parameter int COUNT_WIDTH = CMT_COUNT_WIDTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire item_t item,
    output result_t    result
);

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] cmp_a_reg, cmp_a_next;
    logic [COUNT_WIDTH-1:0] cmp_b_reg, cmp_b_next;
    logic                   run_reg, run_next;
    logic                   oe_reg, oe_next;
    logic                   inv_reg, inv_next;
    logic                   ext_reg, ext_next;
    logic                   clk_en_reg, clk_en_next;
    logic [CODE_W-1:0]      code_reg, code_next;
    logic                   level_reg, level_next;
    logic                   pause_reg, pause_next;

    logic                   active;
    logic                   psc_step;
    psc_ctl_t               psc_ctl;
    logic                   step_en;
    logic                   wrap;
    logic [COUNT_WIDTH-1:0] stepped;
    logic                   hit_a;
    logic [COUNT_WIDTH-1:0] wdata;
    logic [COUNT_WIDTH+DATA_W-1:0] wdata_ext;
    logic [COUNT_WIDTH+DATA_W-1:0] rd_ext;
    logic [DATA_W-1:0]      rd;
    logic                   ma, mb;

    assign active = run_reg && !pause_reg;

    // Prescaler hookup
    always_comb
    begin
        psc_ctl.tick_en = fire && (item.kind == KIND_TICK) && active && clk_en_reg && !ext_reg;
        psc_ctl.clear   = fire && (item.kind == KIND_WRITE) && (item.reg_select == REG_CLKCTL);
        psc_ctl.code    = code_reg;
    end

    cmt_prescale u_prescale (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (psc_ctl),
        .step  (psc_step)
    );

    // Count step: wrap at compare B, else increment at full width
    always_comb
    begin
        step_en = psc_step ||
                  (fire && (item.kind == KIND_EDGE) && active && ext_reg);
        wrap    = (count_reg == cmp_b_reg);
        stepped = wrap ? '0 : count_reg + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
        hit_a   = (stepped == cmp_a_reg);
    end

    // Write data fitted to the counter width
    always_comb
    begin
        wdata_ext = {{COUNT_WIDTH{1'b0}}, item.write_data};
        wdata     = wdata_ext[COUNT_WIDTH-1:0];
    end

    // Read mux
    always_comb
    begin
        rd_ext = '0;
        unique case (item.reg_select)
            REG_CMP_A:  rd_ext = {{DATA_W{1'b0}}, cmp_a_reg};
            REG_CMP_B:  rd_ext = {{DATA_W{1'b0}}, cmp_b_reg};
            REG_COUNT:  rd_ext = {{DATA_W{1'b0}}, count_reg};
            REG_CTRL:   rd_ext[CTRL_INV:0] = {inv_reg, ext_reg, oe_reg, 1'b0, run_reg};
            REG_CLKCTL: rd_ext[CLKCTL_EN:0] = {clk_en_reg, code_reg};
            REG_PAUSE:  rd_ext[0] = pause_reg;
            default:    rd_ext = '0;
        endcase
        rd = (item.kind == KIND_READ) ? rd_ext[DATA_W-1:0] : '0;
    end

    // Next state
    always_comb
    begin
        count_next  = count_reg;
        cmp_a_next  = cmp_a_reg;
        cmp_b_next  = cmp_b_reg;
        run_next    = run_reg;
        oe_next     = oe_reg;
        inv_next    = inv_reg;
        ext_next    = ext_reg;
        clk_en_next = clk_en_reg;
        code_next   = code_reg;
        level_next  = level_reg;
        pause_next  = pause_reg;
        ma          = 1'b0;
        mb          = 1'b0;

        if (step_en)
        begin
            count_next = stepped;
            ma         = hit_a;
            mb         = wrap;
            if (wrap)
            begin
                level_next = 1'b0;
            end
            else if (hit_a)
            begin
                level_next = 1'b1;
            end
        end

        if (fire && (item.kind == KIND_WRITE))
        begin
            unique case (item.reg_select)
                REG_CMP_A: cmp_a_next = wdata;
                REG_CMP_B: cmp_b_next = wdata;
                REG_COUNT: count_next = wdata;
                REG_CTRL:
                begin
                    if (item.write_data[CTRL_PRESET])
                    begin
                        count_next = '0;
                        level_next = 1'b0;
                    end
                    run_next = item.write_data[CTRL_RUN];
                    oe_next  = item.write_data[CTRL_OE];
                    ext_next = item.write_data[CTRL_EXT];
                    inv_next = item.write_data[CTRL_INV];
                end
                REG_CLKCTL:
                begin
                    code_next   = item.write_data[CODE_W-1:0];
                    clk_en_next = item.write_data[CLKCTL_EN];
                end
                REG_PAUSE: pause_next = item.write_data[0];
                default: ;
            endcase
        end
    end

    // Result beat, seen after this item's update
    always_comb
    begin
        result.read_data    = rd;
        result.timer_output = oe_next && (level_next ^ inv_next);
        result.match_a      = ma;
        result.match_b      = mb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            cmp_a_reg  <= '0;
            cmp_b_reg  <= '0;
            run_reg    <= 1'b0;
            oe_reg     <= 1'b0;
            inv_reg    <= 1'b0;
            ext_reg    <= 1'b0;
            clk_en_reg <= 1'b0;
            code_reg   <= '0;
            level_reg  <= 1'b0;
            pause_reg  <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            cmp_a_reg  <= cmp_a_next;
            cmp_b_reg  <= cmp_b_next;
            run_reg    <= run_next;
            oe_reg     <= oe_next;
            inv_reg    <= inv_next;
            ext_reg    <= ext_next;
            clk_en_reg <= clk_en_next;
            code_reg   <= code_next;
            level_reg  <= level_next;
            pause_reg  <= pause_next;
        end
    end

    // A match-B wrap leaves the counter at zero and the level low
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && wrap |=> count_reg == '0 && !level_reg)
        else $error("match B did not wrap the counter");

    // Register accesses never raise match pulses
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.kind == KIND_WRITE || item.kind == KIND_READ)
            |-> !result.match_a && !result.match_b)
        else $error("match pulse on a register access");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the compare-match timer channel unit.
`timescale 1ns / 1ps

module tb;
    import cmt_pkg::*;

    // Run limit in clock cycles, several times the slowest legal run
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned ERROR_PRINT_MAX = 40;

    // Width of one packed input beat
    localparam int ITEM_W = $bits(item_t);

    // Unused register selects
    localparam logic [SEL_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [SEL_W-1:0] REG_SPARE7 = 3'd7;

    // Register bit masks
    localparam logic [DATA_W-1:0] M_RUN    = DATA_W'(1 << CTRL_RUN);
    localparam logic [DATA_W-1:0] M_PRESET = DATA_W'(1 << CTRL_PRESET);
    localparam logic [DATA_W-1:0] M_OE     = DATA_W'(1 << CTRL_OE);
    localparam logic [DATA_W-1:0] M_EXT    = DATA_W'(1 << CTRL_EXT);
    localparam logic [DATA_W-1:0] M_INV    = DATA_W'(1 << CTRL_INV);
    localparam logic [DATA_W-1:0] M_CLKEN  = DATA_W'(1 << CLKCTL_EN);

    // Prescale codes used by name
    localparam logic [CODE_W-1:0] PSC_DIV1   = 3'd0;
    localparam logic [CODE_W-1:0] PSC_DIV256 = 3'd5;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item_beat = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result_beat;

    // Expected results, oldest first
    result_t     pending_results[$];
    result_t     want_beat;

    int unsigned mismatch_count = 0;
    int unsigned beats_checked = 0;
    int unsigned items_sent = 0;
    int unsigned match_a_seen = 0;
    int unsigned match_b_seen = 0;
    int unsigned input_stall_cycles = 0;
    int unsigned cycle_count = 0;

    // Sender burst state
    int unsigned burst_left = 0;
    bit          gaps_on = 1'b1;

    // Receiver stall state
    int unsigned holdoff_request = 0;
    int unsigned holdoff_left = 0;
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned stall_phase = 0;

    // Timer state as predicted
    logic [DATA_W-1:0] tm_count;
    logic [DATA_W-1:0] tm_cmp_a;
    logic [DATA_W-1:0] tm_cmp_b;
    logic              tm_run;
    logic              tm_oe;
    logic              tm_inv;
    logic              tm_ext;
    logic              tm_clken;
    logic [CODE_W-1:0] tm_code;
    logic [PSC_W-1:0]  tm_psc;
    logic              tm_level;
    logic              tm_pause;

    compare_match_timer_channel_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_beat)
    );

    // Clock, 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Divide ratio: 1, 2, 4 then every other power of two up to 4096
    function automatic int unsigned prescale_ratio(input logic [CODE_W-1:0] code);
        int unsigned c;
        c = 32'(code);
        return 32'd1 << ((c < 3) ? c : 2 * c - 2);
    endfunction

    // One count step with wrap at compare B; B match wins the output level
    function automatic void step_counter(output logic hit_a, output logic hit_b);
        hit_a = 1'b0;
        hit_b = 1'b0;
        if (tm_count == tm_cmp_b)
        begin
            tm_count = '0;
            hit_b = 1'b1;
        end
        else
            tm_count = tm_count + 1'b1;
        if (tm_count == tm_cmp_a)
        begin
            hit_a = 1'b1;
            tm_level = 1'b1;
        end
        if (hit_b)
            tm_level = 1'b0;
    endfunction

    function automatic void timer_clear();
        tm_count = '0;
        tm_cmp_a = '0;
        tm_cmp_b = '0;
        tm_run = 1'b0;
        tm_oe = 1'b0;
        tm_inv = 1'b0;
        tm_ext = 1'b0;
        tm_clken = 1'b0;
        tm_code = '0;
        tm_psc = '0;
        tm_level = 1'b0;
        tm_pause = 1'b0;
    endfunction

    // Advance the predicted timer by one item and return its result beat
    function automatic result_t timer_predict(input item_t it);
        result_t r;
        logic    hit_a;
        logic    hit_b;
        logic    active;
        r = '0;
        hit_a = 1'b0;
        hit_b = 1'b0;
        active = tm_run && !tm_pause;
        case (it.kind)
            KIND_TICK:
            begin
                if (active && tm_clken && !tm_ext)
                begin
                    if (tm_psc + 1 >= prescale_ratio(tm_code))
                    begin
                        tm_psc = '0;
                        step_counter(hit_a, hit_b);
                    end
                    else
                        tm_psc = tm_psc + 1'b1;
                end
            end
            KIND_EDGE:
            begin
                if (active && tm_ext)
                    step_counter(hit_a, hit_b);
            end
            KIND_WRITE:
            begin
                case (it.reg_select)
                    REG_CMP_A: tm_cmp_a = it.write_data;
                    REG_CMP_B: tm_cmp_b = it.write_data;
                    REG_COUNT: tm_count = it.write_data;
                    REG_CTRL:
                    begin
                        // preset clears before the new bits apply
                        if (it.write_data[CTRL_PRESET])
                        begin
                            tm_count = '0;
                            tm_level = 1'b0;
                        end
                        tm_run = it.write_data[CTRL_RUN];
                        tm_oe  = it.write_data[CTRL_OE];
                        tm_ext = it.write_data[CTRL_EXT];
                        tm_inv = it.write_data[CTRL_INV];
                    end
                    REG_CLKCTL:
                    begin
                        tm_code = it.write_data[CODE_W-1:0];
                        tm_clken = it.write_data[CLKCTL_EN];
                        tm_psc = '0;
                    end
                    REG_PAUSE: tm_pause = it.write_data[0];
                    default: ;
                endcase
            end
            default:
            begin
                case (it.reg_select)
                    REG_CMP_A: r.read_data = tm_cmp_a;
                    REG_CMP_B: r.read_data = tm_cmp_b;
                    REG_COUNT: r.read_data = tm_count;
                    REG_CTRL:
                    begin
                        r.read_data[CTRL_RUN] = tm_run;
                        r.read_data[CTRL_OE]  = tm_oe;
                        r.read_data[CTRL_EXT] = tm_ext;
                        r.read_data[CTRL_INV] = tm_inv;
                    end
                    REG_CLKCTL:
                    begin
                        r.read_data[CODE_W-1:0] = tm_code;
                        r.read_data[CLKCTL_EN] = tm_clken;
                    end
                    REG_PAUSE: r.read_data[0] = tm_pause;
                    default: ;
                endcase
            end
        endcase
        r.timer_output = tm_oe ? (tm_level ^ tm_inv) : 1'b0;
        r.match_a = hit_a;
        r.match_b = hit_b;
        return r;
    endfunction

    function automatic item_t make_item(input logic [KIND_W-1:0] k, input logic [SEL_W-1:0] s,
                                        input logic [DATA_W-1:0] d);
        item_t it;
        it.kind = k;
        it.reg_select = s;
        it.write_data = d;
        return it;
    endfunction

    task automatic report_error(input string what, input logic [DATA_W-1:0] got,
                                input logic [DATA_W-1:0] want);
        if (mismatch_count < ERROR_PRINT_MAX)
            $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one beat; valid stays high inside a burst, drops only for a gap
    task automatic send_item(input item_t it);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = 0;
            if (gaps_on && $urandom_range(0, 2) != 0)
                gap = $urandom_range(1, 6);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        item_valid <= 1'b1;
        item_beat <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_results.push_back(timer_predict(it));
        items_sent++;
        burst_left--;
    endtask

    task automatic put_reg(input logic [SEL_W-1:0] s, input logic [DATA_W-1:0] d);
        send_item(make_item(KIND_WRITE, s, d));
    endtask

    task automatic get_reg(input logic [SEL_W-1:0] s);
        send_item(make_item(KIND_READ, s, DATA_W'($urandom)));
    endtask

    task automatic source_ticks(input int unsigned n);
        repeat (n) send_item(make_item(KIND_TICK, SEL_W'($urandom), DATA_W'($urandom)));
    endtask

    // Register map: extremes, write-only preset, unused selects
    task automatic test_register_access();
        put_reg(REG_CMP_A, 16'hffff);
        put_reg(REG_CMP_B, 16'h8000);
        put_reg(REG_COUNT, 16'hfffe);
        get_reg(REG_COUNT);
        put_reg(REG_CTRL, 16'hffff);
        put_reg(REG_CLKCTL, 16'hffff);
        put_reg(REG_PAUSE, 16'hffff);
        put_reg(REG_SPARE7, 16'hffff);
        get_reg(REG_CMP_A);
        get_reg(REG_CMP_B);
        get_reg(REG_COUNT);
        get_reg(REG_CTRL);
        get_reg(REG_CLKCTL);
        get_reg(REG_PAUSE);
        get_reg(REG_SPARE6);
        get_reg(REG_SPARE7);
    endtask

    // Wrap onto compare A of zero, count above B, external edges
    task automatic test_match_cases();
        put_reg(REG_CMP_A, 16'h0000);
        put_reg(REG_CMP_B, 16'h0002);
        put_reg(REG_CTRL, M_RUN | M_OE | M_PRESET);
        put_reg(REG_CLKCTL, M_CLKEN | DATA_W'(PSC_DIV1));
        put_reg(REG_PAUSE, 16'h0000);
        source_ticks(3);
        put_reg(REG_COUNT, 16'hffff);
        source_ticks(1);
        put_reg(REG_CTRL, M_RUN | M_OE | M_EXT | M_INV);
        send_item(make_item(KIND_EDGE, SEL_W'($urandom), DATA_W'($urandom)));
        source_ticks(1);
    endtask

    // Slow divider: a clock control rewrite restarts the prescaler
    task automatic test_slow_prescale();
        put_reg(REG_CMP_A, 16'h0005);
        put_reg(REG_CMP_B, 16'h0006);
        put_reg(REG_COUNT, 16'h0004);
        put_reg(REG_CTRL, M_RUN | M_OE);
        put_reg(REG_CLKCTL, M_CLKEN | DATA_W'(PSC_DIV256));
        source_ticks(100);
        put_reg(REG_CLKCTL, M_CLKEN | DATA_W'(PSC_DIV256));
        source_ticks(255);
        get_reg(REG_COUNT);
        source_ticks(1);
        get_reg(REG_COUNT);
    endtask

    // Random episodes: set up a counting window, mostly small, then mostly clock beats
    task automatic test_random_episodes(input int unsigned quota);
        int unsigned start;
        int unsigned n;
        int unsigned roll;
        logic [DATA_W-1:0] cb;
        logic [DATA_W-1:0] ca;
        logic [DATA_W-1:0] cv;
        logic [DATA_W-1:0] ctl;
        logic [DATA_W-1:0] ck;
        logic [DATA_W-1:0] pz;
        logic ext_on;
        item_t it;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 7)
                cb = DATA_W'($urandom_range(0, 15));
            else if (roll == 7)
                cb = DATA_W'($urandom_range(16, 300));
            else if (roll == 8)
                cb = 16'hffff;
            else
                cb = DATA_W'($urandom);
            ca = DATA_W'($urandom);
            if ($urandom_range(0, 5) != 0)
                ca = DATA_W'($urandom_range(0, cb));
            roll = $urandom_range(0, 7);
            if (roll == 0)
                cv = DATA_W'(16'hffff - $urandom_range(0, 3));
            else if (roll == 1)
                cv = DATA_W'($urandom);
            else
                cv = DATA_W'($urandom_range(0, cb));
            ctl = DATA_W'($urandom);
            ctl[CTRL_RUN] = ($urandom_range(0, 7) != 0);
            ctl[CTRL_PRESET] = ($urandom_range(0, 3) == 0);
            ctl[CTRL_OE] = ($urandom_range(0, 5) != 0);
            ctl[CTRL_EXT] = ($urandom_range(0, 3) == 0);
            ck = DATA_W'($urandom);
            ck[CODE_W-1:0] = CODE_W'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 2)
                                                                 : $urandom_range(0, 7));
            ck[CLKCTL_EN] = ($urandom_range(0, 7) != 0);
            pz = DATA_W'($urandom);
            pz[0] = ($urandom_range(0, 7) == 0);
            ext_on = ctl[CTRL_EXT];

            put_reg(REG_CMP_B, cb);
            put_reg(REG_CMP_A, ca);
            put_reg(REG_COUNT, cv);
            put_reg(REG_CTRL, ctl);
            put_reg(REG_CLKCTL, ck);
            put_reg(REG_PAUSE, pz);

            n = $urandom_range(16, 64);
            repeat (n)
            begin
                roll = $urandom_range(0, 19);
                it = ITEM_W'($urandom);
                if (roll < 13)
                    it.kind = (ext_on ^ (roll == 0)) ? KIND_EDGE : KIND_TICK;
                else if (roll < 16)
                    it.kind = KIND_READ;
                else if (roll == 16)
                begin
                    it.kind = KIND_WRITE;
                    it.reg_select = REG_PAUSE;
                end
                else if (roll == 17)
                    it.kind = KIND_WRITE;
                else if (roll == 18)
                begin
                    it.kind = KIND_WRITE;
                    it.reg_select = REG_COUNT;
                end
                // roll 19 leaves a fully random beat
                if (it.kind == KIND_WRITE && it.reg_select == REG_CTRL)
                    ext_on = it.write_data[CTRL_EXT];
                send_item(it);
            end
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        gaps_on = 1'b0;
        holdoff_request = 120;
        repeat (60)
            send_item(make_item(($urandom_range(0, 1) != 0) ? KIND_TICK : KIND_READ,
                                SEL_W'($urandom), DATA_W'($urandom)));
        gaps_on = 1'b1;
    endtask

    // Receiver stall pattern: modes of random length plus requested hold-offs
    always @(posedge clk)
    begin
        if (holdoff_request != 0)
        begin
            holdoff_left = holdoff_request;
            holdoff_request = 0;
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        stall_phase++;
        if (holdoff_left != 0)
        begin
            holdoff_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                2: result_stall <= ($urandom_range(0, 4) < 3);
                default: result_stall <= (stall_phase % 5 < 2);
            endcase
        end
    end

    // Result checker: compare each taken beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                report_error("result beat with nothing pending", result_beat.read_data, '0);
            else
            begin
                want_beat = pending_results.pop_front();
                if (result_beat.read_data !== want_beat.read_data)
                    report_error("read_data", result_beat.read_data, want_beat.read_data);
                if (result_beat.timer_output !== want_beat.timer_output)
                    report_error("timer_output", DATA_W'(result_beat.timer_output),
                                 DATA_W'(want_beat.timer_output));
                if (result_beat.match_a !== want_beat.match_a)
                    report_error("match_a", DATA_W'(result_beat.match_a),
                                 DATA_W'(want_beat.match_a));
                if (result_beat.match_b !== want_beat.match_b)
                    report_error("match_b", DATA_W'(result_beat.match_b),
                                 DATA_W'(want_beat.match_b));
                beats_checked++;
                if (want_beat.match_a)
                    match_a_seen++;
                if (want_beat.match_b)
                    match_b_seen++;
            end
        end
    end

    // Cycle limit and input stall count
    always @(posedge clk)
    begin
        cycle_count++;
        if (item_valid && item_stall)
            input_stall_cycles++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        timer_clear();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_match_cases();
        test_slow_prescale();
        test_random_episodes(1490);
        test_backpressure();

        // drain
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered all register selects, source ticks at every prescale code, external");
        $display("edges, wraps and pauses: %0d beats in, %0d out, %0d A / %0d B matches, %0d stalls",
                 items_sent, beats_checked, match_a_seen, match_b_seen, input_stall_cycles);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
